@@ design/bwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bwm_pkg;

  localparam int MaxCols = 1024;
  localparam int ColW    = 10;
  localparam int ColCntW = 11;
  localparam int RowW    = 16;
  localparam int PipeLen = 6;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  localparam logic RegNumRows = 1'b0;
  localparam logic RegNumCols = 1'b1;

  // one item's bookkeeping as it travels beside the arithmetic
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] col;
    logic            last_row;
    logic            last_col;
  } tag_t;

endpackage
`default_nettype wire

@@ design/bwm_acc_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bwm_acc_mem (
  input  wire                   clk_i,
  input  wire                   we_i,
  input  wire [bwm_pkg::ColW-1:0] waddr_i,
  input  wire [31:0]            wdata_i,
  input  wire                   re_i,
  input  wire [bwm_pkg::ColW-1:0] raddr_i,
  output logic [31:0]           rdata_o
);
  import bwm_pkg::*;

  logic [31:0] mem_q [MaxCols];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ design/bwm_fma.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bwm_fma (
  input  wire        clk_i,
  input  wire        en_i,
  input  wire [31:0] x_i,
  input  wire [15:0] w_i,
  input  wire [31:0] acc_i,
  input  wire        first_i,
  output logic [31:0] res_o
);
  import bwm_pkg::*;

  // normalize so bit 31 is set; returns {lz, sig}
  function automatic logic [36:0] norm32(input logic [31:0] v);
    logic [31:0] s;
    logic [4:0]  n;
    s = v;
    n = '0;
    if (s[31:16] == '0) begin s = s << 16; n[4] = 1'b1; end
    if (s[31:24] == '0) begin s = s << 8;  n[3] = 1'b1; end
    if (s[31:28] == '0) begin s = s << 4;  n[2] = 1'b1; end
    if (s[31:30] == '0) begin s = s << 2;  n[1] = 1'b1; end
    if (s[31] == 1'b0)  begin s = s << 1;  n[0] = 1'b1; end
    return {n, s};
  endfunction

  // normalize so bit 65 is set; returns {lz, sig}
  function automatic logic [72:0] norm66(input logic [65:0] v);
    logic [65:0] s;
    logic [6:0]  n;
    s = v;
    n = '0;
    if (s[65:2] == '0)  begin s = s << 64; n[6] = 1'b1; end
    if (s[65:34] == '0) begin s = s << 32; n[5] = 1'b1; end
    if (s[65:50] == '0) begin s = s << 16; n[4] = 1'b1; end
    if (s[65:58] == '0) begin s = s << 8;  n[3] = 1'b1; end
    if (s[65:62] == '0) begin s = s << 4;  n[2] = 1'b1; end
    if (s[65:64] == '0) begin s = s << 2;  n[1] = 1'b1; end
    if (s[65] == 1'b0)  begin s = s << 1;  n[0] = 1'b1; end
    return {n, s};
  endfunction

  // ---------------- stage A: unpack and multiply ----------------
  logic [7:0]  ex, ew, ea;
  logic [7:0]  ex_eff, ew_eff, ea_eff;
  logic [23:0] sig_x, sig_a;
  logic [7:0]  sig_w;
  logic        x_nan, x_inf, x_zero, w_nan, w_inf, w_zero, a_nan, a_inf, a_zero;
  logic        p_nan, p_inf, sp, sa;
  logic        sp_nan_d, sp_inf_d, sp_infs_d;

  always_comb begin
    ex = x_i[30:23];
    ew = w_i[14:7];
    ea = acc_i[30:23];
    ex_eff = (ex == 8'd0) ? 8'd1 : ex;
    ew_eff = (ew == 8'd0) ? 8'd1 : ew;
    ea_eff = (ea == 8'd0) ? 8'd1 : ea;
    sig_x = {ex != 8'd0, x_i[22:0]};
    sig_w = {ew != 8'd0, w_i[6:0]};
    sig_a = {ea != 8'd0, acc_i[22:0]};
    x_nan  = (ex == 8'hFF) && (x_i[22:0] != '0);
    x_inf  = (ex == 8'hFF) && (x_i[22:0] == '0);
    x_zero = (ex == 8'd0) && (x_i[22:0] == '0);
    w_nan  = (ew == 8'hFF) && (w_i[6:0] != '0);
    w_inf  = (ew == 8'hFF) && (w_i[6:0] == '0);
    w_zero = (ew == 8'd0) && (w_i[6:0] == '0);
    a_nan  = !first_i && (ea == 8'hFF) && (acc_i[22:0] != '0);
    a_inf  = !first_i && (ea == 8'hFF) && (acc_i[22:0] == '0);
    a_zero = (ea == 8'd0) && (acc_i[22:0] == '0);
    sp = x_i[31] ^ w_i[15];
    // on the first row the stored sum is not used, so keep its sign out
    sa = first_i ? sp : acc_i[31];
    p_nan = x_nan || w_nan || (x_inf && w_zero) || (w_inf && x_zero);
    p_inf = (x_inf || w_inf) && !p_nan;
    sp_nan_d  = p_nan || a_nan || (p_inf && a_inf && (sp != sa));
    sp_inf_d  = !sp_nan_d && (p_inf || a_inf);
    sp_infs_d = p_inf ? sp : sa;
  end

  logic               a_sp_q, a_sa_q, a_pz_q, a_az_q, a_first_q;
  logic               a_nan_q, a_inf_q, a_infs_q;
  logic [31:0]        a_sigp_q, a_siga_q;
  logic signed [11:0] a_tp_q, a_ta_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sigp_q  <= sig_x * sig_w;
      a_siga_q  <= {sig_a, 8'd0};
      a_tp_q    <= $signed({4'd0, ex_eff}) + $signed({4'd0, ew_eff}) + 12'sd16;
      a_ta_q    <= $signed({4'd0, ea_eff}) + 12'sd142;
      a_sp_q    <= sp;
      a_sa_q    <= sa;
      a_pz_q    <= x_zero || w_zero;
      a_az_q    <= first_i || a_zero;
      a_first_q <= first_i;
      a_nan_q   <= sp_nan_d;
      a_inf_q   <= sp_inf_d;
      a_infs_q  <= sp_infs_d;
    end
  end

  // ---------------- stage B: normalize both operands ----------------
  logic [36:0] np, na;
  assign np = norm32(a_sigp_q);
  assign na = norm32(a_siga_q);

  logic               b_sp_q, b_sa_q, b_pz_q, b_az_q, b_first_q;
  logic               b_nan_q, b_inf_q, b_infs_q;
  logic [31:0]        b_sigp_q, b_siga_q;
  logic signed [11:0] b_tp_q, b_ta_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_sigp_q  <= np[31:0];
      b_siga_q  <= na[31:0];
      b_tp_q    <= a_tp_q - $signed({7'd0, np[36:32]});
      b_ta_q    <= a_ta_q - $signed({7'd0, na[36:32]});
      b_sp_q    <= a_sp_q;
      b_sa_q    <= a_sa_q;
      b_pz_q    <= a_pz_q;
      b_az_q    <= a_az_q;
      b_first_q <= a_first_q;
      b_nan_q   <= a_nan_q;
      b_inf_q   <= a_inf_q;
      b_infs_q  <= a_infs_q;
    end
  end

  // ---------------- stage C: align the smaller operand ----------------
  logic               p_big;
  logic [31:0]        sb, ss;
  logic signed [11:0] tb, ts, dd;
  logic               sgn_b;
  logic [63:0]        full, shifted, mask;
  logic               sticky;
  logic               zsign;

  always_comb begin
    if (b_az_q) begin
      p_big = 1'b1;
    end else if (b_pz_q) begin
      p_big = 1'b0;
    end else begin
      p_big = (b_tp_q > b_ta_q) || ((b_tp_q == b_ta_q) && (b_sigp_q >= b_siga_q));
    end
    sb    = p_big ? b_sigp_q : b_siga_q;
    tb    = p_big ? b_tp_q : b_ta_q;
    sgn_b = p_big ? b_sp_q : b_sa_q;
    ss    = p_big ? (b_az_q ? 32'd0 : b_siga_q) : (b_pz_q ? 32'd0 : b_sigp_q);
    ts    = p_big ? b_ta_q : b_tp_q;
    dd    = (b_az_q || b_pz_q) ? 12'sd0 : (tb - ts);
    full  = {ss, 32'd0};
    if (dd >= 12'sd64) begin
      shifted = '0;
      sticky  = |ss;
    end else begin
      shifted = full >> dd[5:0];
      mask    = ~({64{1'b1}} << dd[5:0]);
      sticky  = |(full & mask);
    end
    if (!shifted[0] && dd >= 12'sd64) mask = '0;
    if (dd < 12'sd64) begin
      mask = ~({64{1'b1}} << dd[5:0]);
    end else begin
      mask = '0;
    end
    zsign = (b_pz_q && b_az_q) ? (b_first_q ? b_sp_q : (b_sp_q & b_sa_q)) : 1'b0;
  end

  logic [65:0]        c_big_q, c_small_q;
  logic               c_sub_q, c_sign_q, c_zsign_q, c_nan_q, c_inf_q, c_infs_q;
  logic signed [11:0] c_tb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_big_q   <= {1'b0, sb, 33'd0};
      c_small_q <= {1'b0, shifted, sticky};
      c_sub_q   <= b_sp_q ^ b_sa_q;
      c_sign_q  <= sgn_b;
      c_zsign_q <= zsign;
      c_tb_q    <= tb;
      c_nan_q   <= b_nan_q;
      c_inf_q   <= b_inf_q;
      c_infs_q  <= b_infs_q;
    end
  end

  // ---------------- stage D: add magnitudes ----------------
  logic [65:0]        d_sum_q;
  logic               d_sign_q, d_zsign_q, d_nan_q, d_inf_q, d_infs_q;
  logic signed [11:0] d_tb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_sum_q   <= c_sub_q ? (c_big_q - c_small_q) : (c_big_q + c_small_q);
      d_sign_q  <= c_sign_q;
      d_zsign_q <= c_zsign_q;
      d_tb_q    <= c_tb_q;
      d_nan_q   <= c_nan_q;
      d_inf_q   <= c_inf_q;
      d_infs_q  <= c_infs_q;
    end
  end

  // ---------------- stage E: normalize the sum ----------------
  logic [72:0] ns;
  assign ns = norm66(d_sum_q);

  logic [65:0]        e_n_q;
  logic signed [11:0] e_exp_q;
  logic               e_zero_q, e_sign_q, e_zsign_q, e_nan_q, e_inf_q, e_infs_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_n_q     <= ns[65:0];
      e_exp_q   <= d_tb_q - 12'sd141 - $signed({5'd0, ns[72:66]});
      e_zero_q  <= (d_sum_q == '0);
      e_sign_q  <= d_sign_q;
      e_zsign_q <= d_zsign_q;
      e_nan_q   <= d_nan_q;
      e_inf_q   <= d_inf_q;
      e_infs_q  <= d_infs_q;
    end
  end

  // ---------------- round and pack ----------------
  logic signed [11:0] dn;
  logic [5:0]         sh;
  logic [65:0]        xs, smask;
  logic [23:0]        mant;
  logic               g, st, rnd;
  logic [7:0]         ef;
  logic [30:0]        packed_v;

  always_comb begin
    dn = 12'sd1 - e_exp_q;
    if (e_exp_q >= 12'sd1) begin
      sh = 6'd0;
    end else if (dn > 12'sd63) begin
      sh = 6'd63;
    end else begin
      sh = dn[5:0];
    end
    xs    = e_n_q >> sh;
    smask = ~({66{1'b1}} << sh);
    mant  = xs[65:42];
    g     = xs[41];
    st    = (|xs[40:0]) || (|(e_n_q & smask));
    rnd   = g && (st || mant[0]);
    ef    = (e_exp_q >= 12'sd1) ? e_exp_q[7:0] : 8'd0;
    packed_v = {ef, mant[22:0]} + {30'd0, rnd};
    if (e_nan_q) begin
      res_o = CanonNan;
    end else if (e_inf_q) begin
      res_o = {e_infs_q, 8'hFF, 23'd0};
    end else if (e_zero_q) begin
      res_o = {e_zsign_q, 31'd0};
    end else if (e_exp_q >= 12'sd255) begin
      res_o = {e_sign_q, 8'hFF, 23'd0};
    end else begin
      res_o = {e_sign_q, packed_v};
    end
  end

endmodule
`default_nettype wire

@@ design/bf16_weight_matvec_accumulate_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Streaming matrix-vector product y[k] = sum_j x[j] * w[j][k] with bf16
// weights and fp32 accumulation (single rounding per fused multiply-add).
// Input channel s_axis: one weight per transfer in row-major order, each
// carrying its row's fp32 x. Output channel m_axis: one transfer per item of
// the last row with the finished y, its column, and tlast on the final column.
// Configuration: cfg_we_i writes num_rows (index 0) or num_cols (index 1);
// any write restarts the vector. Write only while the block is idle.
// Per-column sums live in a 1024-entry single-port-read memory with a
// registered read port. Throughput is one item per cycle when num_cols is
// at least 7 and the output is not stalled; with fewer columns an item that
// must read a sum still in the 6-deep arithmetic pipeline waits until that
// sum has been written back. Reset clears the counters and sets both counts
// to one; the sum memory is not cleared, since row 0 writes each column
// before its stored sum is used.
// When the receiver stalls, the pipeline keeps accepting items until a
// result-producing item reaches its end while the output register is full.
module bf16_weight_matvec_accumulate_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // x_bits[31:0], weight_bits[47:32]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // y_bits[31:0], column_index[41:32], zero
  output logic        m_axis_tlast,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);
  import bwm_pkg::*;

  logic [RowW-1:0]    num_rows_q;
  logic [ColCntW-1:0] num_cols_q;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    rows_eff;
  logic [ColCntW-1:0] cols_eff;
  logic               is_first, is_last_row, is_last_col;

  tag_t               tag_q [PipeLen];
  logic               advance, hazard, fire;
  logic [31:0]        x_q;
  logic [15:0]        w_q;
  logic               first_q;
  logic [31:0]        rdata, res;
  logic               out_valid_q;
  logic [31:0]        out_y_q;
  logic [ColW-1:0]    out_col_q;
  logic               out_last_q;

  always_comb begin
    rows_eff = (num_rows_q == '0) ? RowW'(1) : num_rows_q;
    if (num_cols_q == '0) begin
      cols_eff = ColCntW'(1);
    end else if (num_cols_q > ColCntW'(MaxCols)) begin
      cols_eff = ColCntW'(MaxCols);
    end else begin
      cols_eff = num_cols_q;
    end
    is_first    = (row_q == '0);
    is_last_row = (row_q == rows_eff - RowW'(1));
    is_last_col = ({1'b0, col_q} == cols_eff - ColCntW'(1));
  end

  // hold the input while a sum this item needs is still in flight
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < PipeLen; i++) begin
      if (tag_q[i].valid && (tag_q[i].col == col_q)) hazard = 1'b1;
    end
    hazard  = hazard && !is_first;
    advance = !(tag_q[PipeLen-1].valid && tag_q[PipeLen-1].last_row &&
                out_valid_q && !m_axis_tready);
    s_axis_tready = advance && !hazard;
    fire = s_axis_tvalid && s_axis_tready;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (fire) begin
      if (is_last_col) begin
        col_d = '0;
        row_d = is_last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= RowW'(1);
      num_cols_q <= ColCntW'(1);
      row_q      <= '0;
      col_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNumRows: num_rows_q <= cfg_data_i;
        RegNumCols: num_cols_q <= cfg_data_i[ColCntW-1:0];
        default: ;
      endcase
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      x_q     <= s_axis_tdata[31:0];
      w_q     <= s_axis_tdata[47:32];
      first_q <= is_first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PipeLen; i++) begin
        tag_q[i] <= '0;
      end
    end else if (advance) begin
      tag_q[0] <= '{valid: fire, col: col_q, last_row: is_last_row, last_col: is_last_col};
      for (int i = 1; i < PipeLen; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  bwm_acc_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (advance && tag_q[PipeLen-1].valid),
    .waddr_i (tag_q[PipeLen-1].col),
    .wdata_i (res),
    .re_i    (fire),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  bwm_fma u_fma (
    .clk_i   (clk_i),
    .en_i    (advance),
    .x_i     (x_q),
    .w_i     (w_q),
    .acc_i   (rdata),
    .first_i (first_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && tag_q[PipeLen-1].valid && tag_q[PipeLen-1].last_row) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tag_q[PipeLen-1].valid && tag_q[PipeLen-1].last_row) begin
      out_y_q    <= res;
      out_col_q  <= tag_q[PipeLen-1].col;
      out_last_q <= tag_q[PipeLen-1].last_col;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_col_q, out_y_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

@@ verif/bf16_weight_matvec_accumulate_core_test.sv @@
`timescale 1ns / 1ps
module bf16_weight_matvec_accumulate_core_test;
  import bwm_pkg::*;

  typedef struct {
    logic [31:0]     y;
    logic [ColW-1:0] col;
    logic            last;
  } col_result_t;

  logic        clk;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // x_bits[31:0], weight_bits[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // y_bits[31:0], column_index[41:32], zero
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  // predictor state
  logic [31:0]  col_sums [MaxCols];
  int           row_pos;
  int           col_pos;
  logic [15:0]  rows_reg;
  logic [10:0]  cols_reg;
  col_result_t  y_expected [$];

  int errors;
  int items_sent;
  int results_seen;
  int rx_hold;
  int rx_wait;
  bit rx_quiet;
  bit tx_quiet;

  bf16_weight_matvec_accumulate_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #30_000_000;
    $display("bf16_weight_matvec_accumulate_core test failed");
    $finish;
  end

  function automatic bit f32_is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic bit f32_is_inf(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] == 0;
  endfunction

  function automatic bit f32_is_zero(logic [31:0] b);
    return b[30:0] == 0;
  endfunction

  // significand and exponent such that value = sig * 2^exp
  function automatic void f32_split(input logic [31:0] b, output logic [23:0] sig,
                                    output int ex);
    if (b[30:23] == 0) begin
      sig = {1'b0, b[22:0]};
      ex  = -149;
    end else begin
      sig = {1'b1, b[22:0]};
      ex  = int'(b[30:23]) - 150;
    end
  endfunction

  // round sign * mag * 2^ex to fp32, nearest even; mag is nonzero
  function automatic logic [31:0] f32_round(logic s, logic [159:0] mag, int ex);
    int top;
    int lsb_ex;
    int sh;
    logic [159:0] q;
    logic [159:0] kept;
    logic guard;
    logic sticky;
    top = 0;
    for (int i = 0; i < 160; i++) if (mag[i]) top = i;
    top = top + ex;
    if (top > 127) return {s, 8'hFF, 23'h0};
    lsb_ex = top - 23;
    if (lsb_ex < -149) lsb_ex = -149;
    sh = lsb_ex - ex;
    if (sh <= 0) begin
      q = mag << (-sh);
      guard = 1'b0;
      sticky = 1'b0;
    end else begin
      q = mag >> sh;
      guard = (sh - 1 < 160) ? mag[sh-1] : 1'b0;
      kept = (mag >> (sh - 1)) << (sh - 1);
      sticky = (mag & ~kept) != 0;
    end
    if (guard && (sticky || q[0])) q = q + 1;
    if (q[24]) begin
      q = q >> 1;
      lsb_ex++;
    end
    if (q[23]) begin
      if (lsb_ex + 150 > 254) return {s, 8'hFF, 23'h0};
      return {s, 8'(lsb_ex + 150), q[22:0]};
    end
    return {s, 8'h0, q[22:0]};
  endfunction

  // x * w (+ sum unless first row), one rounding
  function automatic logic [31:0] fused_column_update(logic [31:0] x, logic [31:0] w,
                                                      logic [31:0] sum, bit first);
    logic [23:0] xs, ws, as;
    int xe, we, pe, ae, e0;
    logic ps;
    logic [159:0] pm, am, pa, aa, mag;
    bit p_inf, p_zero;
    ps = x[31] ^ w[31];
    if (f32_is_nan(x) || f32_is_nan(w)) return CanonNan;
    if ((f32_is_inf(x) && f32_is_zero(w)) || (f32_is_inf(w) && f32_is_zero(x)))
      return CanonNan;
    p_inf  = f32_is_inf(x) || f32_is_inf(w);
    p_zero = f32_is_zero(x) || f32_is_zero(w);
    f32_split(x, xs, xe);
    f32_split(w, ws, we);
    pm = 160'(xs) * 160'(ws);
    pe = xe + we;
    if (first) begin
      if (p_inf) return {ps, 8'hFF, 23'h0};
      if (p_zero) return {ps, 31'h0};
      return f32_round(ps, pm, pe);
    end
    if (f32_is_nan(sum)) return CanonNan;
    if (p_inf) begin
      if (f32_is_inf(sum) && sum[31] != ps) return CanonNan;
      return {ps, 8'hFF, 23'h0};
    end
    if (f32_is_inf(sum)) return sum;
    if (p_zero) begin
      if (f32_is_zero(sum)) return {ps & sum[31], 31'h0};
      return sum;
    end
    if (f32_is_zero(sum)) return f32_round(ps, pm, pe);
    f32_split(sum, as, ae);
    am = 160'(as);
    // a far smaller operand only matters as a sticky bit below the larger one
    if (pe - ae > 80) begin
      am = 1;
      ae = pe - 80;
    end else if (ae - pe > 80) begin
      pm = 1;
      pe = ae - 80;
    end
    e0 = (pe < ae) ? pe : ae;
    pa = pm << (pe - e0);
    aa = am << (ae - e0);
    if (ps == sum[31]) return f32_round(ps, pa + aa, e0);
    if (pa == aa) return 32'h0;
    if (pa > aa) return f32_round(ps, pa - aa, e0);
    return f32_round(sum[31], aa - pa, e0);
  endfunction

  function automatic void accumulate_item(logic [31:0] x, logic [15:0] w);
    int rows;
    int cols;
    logic [31:0] acc;
    col_result_t r;
    rows = (rows_reg == 0) ? 1 : int'(rows_reg);
    cols = (cols_reg == 0) ? 1 : int'(cols_reg);
    if (cols > MaxCols) cols = MaxCols;
    if (col_pos >= cols) col_pos = 0;
    if (row_pos >= rows) row_pos = 0;
    acc = fused_column_update(x, {w, 16'h0}, col_sums[col_pos], row_pos == 0);
    col_sums[col_pos] = acc;
    if (row_pos == rows - 1) begin
      r.y    = acc;
      r.col  = col_pos[ColW-1:0];
      r.last = (col_pos == cols - 1);
      y_expected.push_back(r);
    end
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // check each output transfer against the oldest expectation
  always @(posedge clk) begin
    col_result_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
      if (y_expected.size() == 0) begin
        report("unexpected result", m_axis_tdata[31:0], 32'h0);
      end else begin
        r = y_expected.pop_front();
        if (m_axis_tdata[31:0] !== r.y) report("y_bits", m_axis_tdata[31:0], r.y);
        if (m_axis_tdata[41:32] !== r.col)
          report("column_index", 32'(m_axis_tdata[41:32]), 32'(r.col));
        if (m_axis_tlast !== r.last) report("last_output", 32'(m_axis_tlast), 32'(r.last));
      end
    end
  end

  // receiver: long hold-off first, then per-transfer stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        m_axis_tready = 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready = rst_ni;
      end
    end
  end

  // starts and ends at a falling edge
  task automatic send_item(input logic [31:0] x, input logic [15:0] w);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    s_axis_tvalid = 1'b0;
    repeat (gap) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {w, x};
    do @(posedge clk); while (!s_axis_tready);
    accumulate_item(x, w);
    items_sent++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    wait (y_expected.size() == 0);
    @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk);
    cfg_we_i = 1'b0;
    if (idx == RegNumRows) rows_reg = val;
    else cols_reg = val[10:0];
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic set_shape(input logic [15:0] rows, input logic [15:0] cols);
    if ($urandom_range(0, 1)) begin
      write_reg(RegNumRows, rows);
      write_reg(RegNumCols, cols);
    end else begin
      write_reg(RegNumCols, cols);
      write_reg(RegNumRows, rows);
    end
  endtask

  function automatic logic [31:0] pick_x();
    int sel;
    logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0080_0000};
    sel = $urandom_range(0, 99);
    if (sel < 60) return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    if (sel < 75) return $urandom;
    if (sel < 85) return specials[$urandom_range(0, 7)];
    if (sel < 93) return {1'($urandom), 8'($urandom_range(0, 20)), 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(230, 254)), 23'($urandom)};
  endfunction

  function automatic logic [15:0] pick_w();
    int sel;
    logic [15:0] specials [6] = '{16'h0, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC1, 16'h0001};
    sel = $urandom_range(0, 99);
    if (sel < 65) return {1'($urandom), 8'($urandom_range(118, 136)), 7'($urandom)};
    if (sel < 85) return 16'($urandom);
    if (sel < 93) return specials[$urandom_range(0, 5)];
    return {1'($urandom), 8'($urandom_range(0, 30)), 7'($urandom)};
  endfunction

  task automatic test_single_items();
    // one row, one column: every transfer returns its own rounded product
    send_item(32'h0000_0000, 16'h0000);
    send_item(32'h8000_0000, 16'h3F80);
    send_item(32'h7F80_0000, 16'h0000);
    send_item(32'h7F7F_FFFF, 16'h7F7F);
    send_item(32'h0000_0001, 16'h3F80);
    send_item(32'h0000_0003, 16'h3F00);
    send_item(32'h7FC0_0001, 16'h3F80);
    send_item(32'h3F80_0000, 16'hFF80);
    send_item(32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_accumulate_specials();
    set_shape(16'd2, 16'd2);
    // infinities of both signs cancel to NaN; equal and opposite sums give +0
    send_item(32'h7F80_0000, 16'h3F80);
    send_item(32'h3F80_0000, 16'h3F80);
    send_item(32'h3F80_0000, 16'hFF80);
    send_item(32'hBF80_0000, 16'h3F80);
    set_shape(16'd2, 16'd1);
    // tie to even on the single rounding
    send_item(32'h3F80_0000, 16'h3F80);
    send_item(32'h3380_0000, 16'h3F80);
    send_item(32'h7F7F_FFFF, 16'h3F80);
    send_item(32'h7F7F_FFFF, 16'h3F80);
    send_item(32'h8000_0000, 16'h3F80);
    send_item(32'h0000_0000, 16'hBF80);
  endtask

  task automatic test_count_extremes();
    // zero counts act as one
    set_shape(16'd0, 16'd0);
    send_item(pick_x(), pick_w());
    send_item(pick_x(), pick_w());
    // tall matrix: no row finishes, so nothing comes out
    set_shape(16'hFFFF, 16'd2);
    repeat (16) send_item(pick_x(), pick_w());
    // oversized column count clamps to the full accumulator memory
    set_shape(16'd1, 16'h07FF);
    rx_quiet = $urandom_range(0, 1);
    repeat (MaxCols) send_item(pick_x(), pick_w());
    rx_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_shape(16'd1, 16'd3);
    tx_quiet = 1'b1;
    rx_hold  = 300;
    repeat (60) send_item(pick_x(), pick_w());
    tx_quiet = 1'b0;
    // hold input until the block is empty
    drain();
    set_shape(16'd3, 16'd1);
    repeat (9) send_item(pick_x(), pick_w());
  endtask

  task automatic test_random_vectors();
    int budget;
    int rows;
    int cols;
    int n;
    budget = 0;
    while (budget < 650) begin
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      set_shape(16'(rows), 16'(cols));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      n = rows * cols * $urandom_range(1, 2);
      // cut some vectors short before reconfiguring
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      repeat (n) send_item(pick_x(), pick_w());
      budget += n;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    rx_hold = 0;
    rx_wait = 0;
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    rows_reg = 16'd1;
    cols_reg = 11'd1;
    row_pos = 0;
    col_pos = 0;
    foreach (col_sums[i]) col_sums[i] = 32'h0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 48'h0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegNumRows;
    cfg_data_i = 16'h0;
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_single_items();
    test_accumulate_specials();
    test_count_extremes();
    test_backpressure();
    test_random_vectors();

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d weight transfers and %0d column results,", items_sent, results_seen);
    $display("with special values, clamped counts, long output stalls and random shapes");
    if (errors == 0 && y_expected.size() == 0) begin
      $display("bf16_weight_matvec_accumulate_core test passed");
    end else begin
      $display("bf16_weight_matvec_accumulate_core test failed");
    end
    $finish;
  end

endmodule
